// ===== src/gmb_pkg.sv =====
package gmb_pkg;

  // register, input and output field widths
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned OUT_NUM_W = 11;
  localparam int unsigned ROW_IN_W  = 5;
  localparam int unsigned COL_IN_W  = 5;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SEED  = 7'b0000100,
    S_HEAD  = 7'b0001000,
    S_CELL  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

endpackage

// ===== src/grid_maze_bfs_core.sv =====
// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o   | mode_i, row_i, col_i, blocked_i
// out     | output    | out_valid_o / out_stall_i | goal_reached_o, visited_count_o,
//         |           |                           | visit_number_o
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// load and read words go from idle straight to the finish state; a search takes one pass
// over the visit store (2**(row bits + col bits) entries, 1024 by default) and then, per
// dequeued cell, one queue read and four neighbor reads and write-backs through that store.
// after reset a clearing pass over every address wipes both stores; no word is taken then.
// one word is in work at a time; a finished result waits in the output register while
// the next word is taken, and out_stall_i holds it there.
module grid_maze_bfs_core #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLS    = 32,
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [gmb_pkg::ROW_IN_W-1:0]   row_i,
  input  logic [gmb_pkg::COL_IN_W-1:0]   col_i,
  input  logic                           blocked_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           goal_reached_o,
  output logic [gmb_pkg::OUT_NUM_W-1:0]  visited_count_o,
  output logic [gmb_pkg::OUT_NUM_W-1:0]  visit_number_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [gmb_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned NUM_W = $clog2(MAX_ROWS * MAX_COLS + 2);
  localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW   = $clog2(QUEUE_DEPTH + 1);

  gmb_pkg::state_e state_q, state_d;

  logic [gmb_pkg::CFG_W-1:0] row_count_q, col_count_q;

  logic [AW-1:0]    clr_q, clr_d;
  logic             clr_obs_q, clr_obs_d;
  logic [QCW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [NUM_W-1:0] next_q, next_d;
  logic             reached_q, reached_d;
  logic [2:0]       k_q, k_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic             out_valid_q, out_valid_d;

  gmb_pkg::mode_e mode_q;
  logic           in_range_q;

  logic                         goal_q;
  logic [gmb_pkg::OUT_NUM_W-1:0] cnt_q, num_q;

  // storage
  logic             obs_mem [2**AW];
  logic [NUM_W-1:0] vis_mem [2**AW];
  logic [AW-1:0]    q_mem   [QUEUE_DEPTH];
  logic             obs_rd_q;
  logic [NUM_W-1:0] vis_rd_q;
  logic [AW-1:0]    q_rd_q;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             obs_we, obs_wdata;
  logic [AW-1:0]    obs_waddr;
  logic             vis_we;
  logic [AW-1:0]    vis_waddr;
  logic [NUM_W-1:0] vis_wdata;
  logic             q_we, q_re;
  logic [QW-1:0]    q_waddr;
  logic [AW-1:0]    q_wdata;

  logic          accept, out_free, in_range;
  logic [AW-1:0] in_addr;
  logic [RW-1:0] rc_m1, cur_r;
  logic [CW-1:0] cc_m1, cur_c;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;

  assign in_stall_o = (state_q != gmb_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_range = (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS);
  assign in_addr  = {RW'(row_i), CW'(col_i)};

  always_comb begin
    if (row_count_q == '0) begin
      rc_m1 = '0;
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rc_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rc_m1 = RW'(row_count_q - gmb_pkg::CFG_W'(1));
    end
    if (col_count_q == '0) begin
      cc_m1 = '0;
    end else if (32'(col_count_q) > MAX_COLS) begin
      cc_m1 = CW'(MAX_COLS - 1);
    end else begin
      cc_m1 = CW'(col_count_q - gmb_pkg::CFG_W'(1));
    end
  end

  assign cur_r = q_rd_q[AW-1:CW];
  assign cur_c = q_rd_q[CW-1:0];

  // neighbor order: down, right, left, up
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = q_rd_q;
    unique case (k_q[1:0])
      2'd0: begin
        nb_ok   = (cur_r < rc_m1);
        nb_addr = {cur_r + RW'(1), cur_c};
      end
      2'd1: begin
        nb_ok   = (cur_c < cc_m1);
        nb_addr = {cur_r, cur_c + CW'(1)};
      end
      2'd2: begin
        nb_ok   = (cur_c != '0);
        nb_addr = {cur_r, cur_c - CW'(1)};
      end
      default: begin
        nb_ok   = (cur_r != '0);
        nb_addr = {cur_r - RW'(1), cur_c};
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clr_obs_d   = clr_obs_q;
    head_d      = head_q;
    tail_d      = tail_q;
    next_d      = next_q;
    reached_d   = reached_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    out_valid_d = out_valid_q && out_stall_i;

    rd_en     = 1'b0;
    rd_addr   = in_addr;
    obs_we    = 1'b0;
    obs_waddr = clr_q;
    obs_wdata = 1'b0;
    vis_we    = 1'b0;
    vis_waddr = clr_q;
    vis_wdata = '0;
    q_we      = 1'b0;
    q_re      = 1'b0;
    q_waddr   = tail_q[QW-1:0];
    q_wdata   = pend_addr_q;

    unique case (state_q)
      gmb_pkg::S_CLEAR: begin
        vis_we = 1'b1;
        obs_we = clr_obs_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == '1) begin
          clr_obs_d = 1'b0;
          state_d   = clr_obs_q ? gmb_pkg::S_IDLE : gmb_pkg::S_SEED;
        end
      end
      gmb_pkg::S_IDLE: begin
        if (accept) begin
          state_d = gmb_pkg::S_FIN;
          unique case (gmb_pkg::mode_e'(mode_i))
            gmb_pkg::MODE_LOAD: begin
              obs_we    = in_range;
              obs_waddr = in_addr;
              obs_wdata = blocked_i;
            end
            gmb_pkg::MODE_SEARCH: begin
              clr_d   = '0;
              state_d = gmb_pkg::S_CLEAR;
            end
            gmb_pkg::MODE_READ: begin
              rd_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      gmb_pkg::S_SEED: begin
        // start cell is numbered 1 and queued without a block check
        vis_we    = 1'b1;
        vis_waddr = '0;
        vis_wdata = NUM_W'(1);
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = '0;
        head_d    = '0;
        tail_d    = QCW'(1);
        next_d    = NUM_W'(2);
        reached_d = 1'b0;
        state_d   = gmb_pkg::S_HEAD;
      end
      gmb_pkg::S_HEAD: begin
        if (head_q < tail_q) begin
          q_re    = 1'b1;
          state_d = gmb_pkg::S_CELL;
        end else begin
          state_d = gmb_pkg::S_FIN;
        end
      end
      gmb_pkg::S_CELL: begin
        if (cur_r == rc_m1 && cur_c == cc_m1) begin
          reached_d = 1'b1;
          state_d   = gmb_pkg::S_FIN;
        end else begin
          k_d     = '0;
          state_d = gmb_pkg::S_SCAN;
        end
      end
      gmb_pkg::S_SCAN: begin
        // issue the read of neighbor k while the result of neighbor k-1 is checked
        if (k_q != 3'd4) begin
          rd_en       = nb_ok;
          rd_addr     = nb_addr;
          pend_d      = nb_ok;
          pend_addr_d = nb_addr;
          k_d         = k_q + 3'd1;
        end else begin
          head_d  = head_q + QCW'(1);
          state_d = gmb_pkg::S_HEAD;
        end
        if (pend_q && !obs_rd_q && vis_rd_q == '0) begin
          vis_we    = 1'b1;
          vis_waddr = pend_addr_q;
          vis_wdata = next_q;
          next_d    = next_q + NUM_W'(1);
          if (tail_q < QCW'(QUEUE_DEPTH)) begin
            q_we   = 1'b1;
            tail_d = tail_q + QCW'(1);
          end
        end
      end
      gmb_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = gmb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gmb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmb_pkg::S_CLEAR;
      row_count_q <= gmb_pkg::CFG_W'(32);
      col_count_q <= gmb_pkg::CFG_W'(32);
      clr_q       <= '0;
      clr_obs_q   <= 1'b1;
      head_q      <= '0;
      tail_q      <= '0;
      next_q      <= '0;
      reached_q   <= 1'b0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_obs_q   <= clr_obs_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      next_q      <= next_d;
      reached_q   <= reached_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (gmb_pkg::cfg_idx_e'(cfg_idx_i))
          gmb_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i;
          gmb_pkg::REG_COL_COUNT: col_count_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    if (accept) begin
      mode_q     <= gmb_pkg::mode_e'(mode_i);
      in_range_q <= in_range;
    end
    if (state_q == gmb_pkg::S_FIN && out_free) begin
      goal_q <= reached_q;
      cnt_q  <= (next_q == '0) ? '0 : gmb_pkg::OUT_NUM_W'(next_q - NUM_W'(1));
      num_q  <= (mode_q == gmb_pkg::MODE_READ && in_range_q) ?
                gmb_pkg::OUT_NUM_W'(vis_rd_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obs_we) begin
      obs_mem[obs_waddr] <= obs_wdata;
    end
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (rd_en) begin
      obs_rd_q <= obs_mem[rd_addr];
      vis_rd_q <= vis_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= q_mem[head_q[QW-1:0]];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign goal_reached_o  = goal_q;
  assign visited_count_o = cnt_q;
  assign visit_number_o  = num_q;

  head_within_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed the tail");

  word_only_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gmb_pkg::S_FIN))
    else $error("result word raised outside the finish state");

  check_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == gmb_pkg::S_SCAN))
    else $error("neighbor check without a scan read");

  cell_after_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gmb_pkg::S_CELL |-> $past(state_q == gmb_pkg::S_HEAD && head_q < tail_q))
    else $error("cell examined without a queue read");

endmodule
